[rtl/tlms_pkg.sv]
// Package with types, constants and codes shared by the tank level step block.
package tlms_pkg;

    localparam int VALUE_BITS = 48;
    localparam int FRAC_BITS  = 16;
    localparam int ACC_BITS   = 2 * VALUE_BITS;
    localparam int CNT_BITS   = $clog2(ACC_BITS + 1);

    localparam logic [VALUE_BITS-1:0] MAXV    = {VALUE_BITS{1'b1}};
    localparam logic [VALUE_BITS-1:0] ONE_Q   = VALUE_BITS'(64'd1 << FRAC_BITS);
    localparam logic [VALUE_BITS-1:0] K_AREA  =
        VALUE_BITS'(((64'd785 << FRAC_BITS) + 64'd500) / 64'd1000);
    localparam logic [VALUE_BITS-1:0] K_G     =
        VALUE_BITS'(((64'd981 << FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic [VALUE_BITS-1:0] P_ATM   = VALUE_BITS'(64'd101300 << FRAC_BITS);
    localparam logic [VALUE_BITS-1:0] C_100   = VALUE_BITS'(64'd100);
    localparam logic [VALUE_BITS-1:0] C_3600  = VALUE_BITS'(64'd3600);
    localparam logic [VALUE_BITS-1:0] C_3600Q = VALUE_BITS'(64'd3600 << FRAC_BITS);
    localparam logic [VALUE_BITS-1:0] C_ONE   = VALUE_BITS'(64'd1);

    localparam logic [2:0] REG_HEIGHT   = 3'd0;
    localparam logic [2:0] REG_DIAMETER = 3'd1;
    localparam logic [2:0] REG_PORT     = 3'd2;
    localparam logic [2:0] REG_RESIST   = 3'd3;
    localparam logic [2:0] REG_VALVE    = 3'd4;
    localparam logic [2:0] REG_FILL     = 3'd5;
    localparam logic [2:0] REG_INITCONC = 3'd6;
    localparam logic [2:0] REG_TSTEP    = 3'd7;

    typedef enum logic [4:0] {
        S_IDLE,
        S_AREA1, S_AREA2, S_FULL, S_PORT,
        S_INITVOL, S_LEVEL, S_HEAD1, S_HEAD2,
        S_FLOW1, S_FLOW2, S_FLOW3,
        S_INFLOW, S_SUM, S_MIX, S_VOLUME, S_OUTLEVEL, S_OUTFLOW,
        S_DONE
    } state_t;

    typedef struct packed {
        logic                  start;
        logic [VALUE_BITS-1:0] a;
        logic [VALUE_BITS-1:0] b;
        logic [VALUE_BITS-1:0] c;
    } md_req_t;

endpackage

[rtl/tlms_muldiv.sv]
// Shared multi-cycle unit computing floor(a*b/c) with saturation.
module tlms_muldiv (
    input  logic                           clk,
    input  logic                           rst_n,
    input  tlms_pkg::md_req_t              req,
    output logic                           done,
    output logic [tlms_pkg::VALUE_BITS-1:0] result
);
    import tlms_pkg::*;

    typedef enum logic [1:0] {M_IDLE, M_MUL, M_DIV, M_FIN} md_state_t;

    md_state_t             st_reg, st_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [ACC_BITS-1:0]   prod_reg, prod_next;
    logic [VALUE_BITS-1:0] a_reg, a_next, b_reg, b_next, c_reg, c_next;
    logic [VALUE_BITS:0]   rem_reg, rem_next;
    logic [ACC_BITS-1:0]   q_reg, q_next;
    logic [VALUE_BITS:0]   shifted;

    always_comb
    begin
        st_next   = st_reg;
        cnt_next  = cnt_reg;
        prod_next = prod_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        c_next    = c_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        shifted   = {rem_reg[VALUE_BITS-1:0], prod_reg[ACC_BITS-1]};
        unique case (st_reg)
            M_IDLE:
            begin
                if (req.start)
                begin
                    a_next    = req.a;
                    b_next    = req.b;
                    c_next    = req.c;
                    prod_next = '0;
                    cnt_next  = CNT_BITS'(VALUE_BITS);
                    st_next   = M_MUL;
                end
            end
            M_MUL:
            begin
                prod_next = (prod_reg << 1)
                    + (b_reg[VALUE_BITS-1] ? ACC_BITS'(a_reg) : '0);
                b_next    = b_reg << 1;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == CNT_BITS'(1))
                begin
                    rem_next = '0;
                    q_next   = '0;
                    cnt_next = CNT_BITS'(ACC_BITS);
                    st_next  = M_DIV;
                end
            end
            M_DIV:
            begin
                prod_next = prod_reg << 1;
                if (shifted >= {1'b0, c_reg})
                begin
                    rem_next = shifted - {1'b0, c_reg};
                    q_next   = {q_reg[ACC_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next = shifted;
                    q_next   = {q_reg[ACC_BITS-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_BITS'(1))
                begin
                    st_next = M_FIN;
                end
            end
            M_FIN:
            begin
                st_next = M_IDLE;
            end
            default:
            begin
                st_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= M_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            st_reg  <= st_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        c_reg    <= c_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
    end

    assign done   = (st_reg == M_FIN);
    assign result = (c_reg == '0 || q_reg[ACC_BITS-1:VALUE_BITS] != '0)
                    ? MAXV : q_reg[VALUE_BITS-1:0];

    property p_start_idle;
        @(posedge clk) disable iff (!rst_n) req.start |-> st_reg == M_IDLE;
    endproperty
    a_start_idle: assert property (p_start_idle) else $error("start while busy");

    property p_fin_once;
        @(posedge clk) disable iff (!rst_n) st_reg == M_FIN |=> st_reg == M_IDLE;
    endproperty
    a_fin_once: assert property (p_fin_once) else $error("done held");

    property p_mul_to_div;
        @(posedge clk) disable iff (!rst_n)
            (st_reg == M_MUL && cnt_reg == CNT_BITS'(1)) |=> st_reg == M_DIV;
    endproperty
    a_mul_to_div: assert property (p_mul_to_div) else $error("bad phase change");

endmodule

[rtl/tank_level_mixing_step.sv]
// Top level of the tank level, outlet flow and concentration mixing step.
// Each transfer is worked through one shared multiply-divide unit, in which an
// operation takes 48 multiply steps and 96 divide steps plus a start/done handshake.
// A step item uses 11 to 14 operations and an initialise item 10 to 13, fewer when
// the tank area is zero or the level is not above the port. in_stall stays high
// until the result is in the output register, and longer while a previous result
// is still held there.
module tank_level_mixing_step (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            action,
    input  logic [tlms_pkg::VALUE_BITS-1:0] inflow_rate,
    input  logic [tlms_pkg::VALUE_BITS-1:0] density,
    input  logic [tlms_pkg::VALUE_BITS-1:0] inflow_concentration,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [tlms_pkg::VALUE_BITS-1:0] liquid_level,
    output logic [tlms_pkg::VALUE_BITS-1:0] liquid_concentration,
    output logic [tlms_pkg::VALUE_BITS-1:0] outflow_rate,
    output logic [tlms_pkg::VALUE_BITS-1:0] outlet_pressure,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [2:0]                      cfg_index,
    input  logic [tlms_pkg::VALUE_BITS-1:0] cfg_data
);
    import tlms_pkg::*;

    state_t                st_reg, st_next;
    logic                  busy_reg, busy_next;
    logic                  act_reg;
    logic [VALUE_BITS-1:0] infl_reg, dens_reg, cin_reg;
    logic [VALUE_BITS-1:0] height_reg, diam_reg, resist_reg, iconc_reg, tstep_reg;
    logic [16:0]           port_frac_reg;
    logic [6:0]            valve_reg, fill_reg;
    logic [VALUE_BITS-1:0] vol_reg, vol_next, conc_reg, conc_next;
    logic [VALUE_BITS-1:0] area_reg, area_next, full_reg, full_next;
    logic [VALUE_BITS-1:0] port_reg, port_next, lvl_reg, lvl_next;
    logic [VALUE_BITS-1:0] t_reg, t_next, press_reg, press_next;
    logic [VALUE_BITS-1:0] fout_reg, fout_next, fin_reg, fin_next, tot_reg, tot_next;
    logic                  ovalid_reg, ovalid_next;
    logic [VALUE_BITS-1:0] o_lvl_reg, o_conc_reg, o_flow_reg, o_press_reg;
    logic                  load_out;
    logic [VALUE_BITS:0]   psum;
    logic [VALUE_BITS-1:0] tot_sum;
    logic                  tot_ovf;
    md_req_t               req;
    logic                  md_done;
    logic [VALUE_BITS-1:0] md_res;
    logic                  issue_reg, issue_next;

    tlms_muldiv u_md (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .done   (md_done),
        .result (md_res)
    );

    assign in_stall  = busy_reg;
    assign cfg_ready = 1'b1;
    assign psum      = {1'b0, P_ATM} + {1'b0, md_res};
    assign {tot_ovf, tot_sum} = {1'b0, vol_reg} + {1'b0, fin_reg};

    always_comb
    begin
        req.start = issue_reg;
        req.a     = '0;
        req.b     = '0;
        req.c     = ONE_Q;
        unique case (st_reg)
            S_AREA1:    begin req.a = diam_reg;   req.b = diam_reg; end
            S_AREA2:    begin req.a = t_reg;      req.b = K_AREA; end
            S_FULL:     begin req.a = area_reg;   req.b = height_reg; end
            S_PORT:     begin req.a = VALUE_BITS'(port_frac_reg); req.b = height_reg; end
            S_INITVOL:  begin req.a = full_reg;   req.b = VALUE_BITS'(fill_reg);
                              req.c = C_100; end
            S_LEVEL, S_OUTLEVEL:
                        begin req.a = vol_reg;    req.b = ONE_Q; req.c = area_reg; end
            S_HEAD1:    begin req.a = dens_reg;   req.b = K_G; end
            S_HEAD2:    begin req.a = t_reg;      req.b = lvl_reg - port_reg; end
            S_FLOW1:    begin req.a = press_reg - P_ATM; req.b = VALUE_BITS'(valve_reg);
                              req.c = C_100; end
            S_FLOW2:    begin req.a = t_reg;      req.b = tstep_reg; end
            S_FLOW3:    begin req.a = t_reg;      req.b = ONE_Q; req.c = resist_reg; end
            S_INFLOW:   begin req.a = infl_reg;   req.b = tstep_reg; req.c = C_3600Q; end
            S_MIX:      begin req.a = (cin_reg >= conc_reg) ? cin_reg - conc_reg
                                                            : conc_reg - cin_reg;
                              req.b = fin_reg;    req.c = tot_reg; end
            S_OUTFLOW:  begin req.a = fout_reg;   req.b = C_3600; req.c = C_ONE; end
            default:    begin req.a = '0; end
        endcase
    end

    always_comb
    begin
        st_next     = st_reg;
        busy_next   = busy_reg;
        issue_next  = 1'b0;
        vol_next    = vol_reg;
        conc_next   = conc_reg;
        area_next   = area_reg;
        full_next   = full_reg;
        port_next   = port_reg;
        lvl_next    = lvl_reg;
        t_next      = t_reg;
        press_next  = press_reg;
        fout_next   = fout_reg;
        fin_next    = fin_reg;
        tot_next    = tot_reg;
        load_out    = 1'b0;
        unique case (st_reg)
            S_IDLE:
            begin
                if (in_valid && !busy_reg)
                begin
                    busy_next  = 1'b1;
                    st_next    = S_AREA1;
                    issue_next = 1'b1;
                end
            end
            S_AREA1: if (md_done) begin t_next = md_res; st_next = S_AREA2; issue_next = 1'b1; end
            S_AREA2: if (md_done) begin area_next = md_res; st_next = S_FULL; issue_next = 1'b1; end
            S_FULL:  if (md_done) begin full_next = md_res; st_next = S_PORT; issue_next = 1'b1; end
            S_PORT:
            begin
                if (md_done)
                begin
                    port_next  = md_res;
                    issue_next = 1'b1;
                    if (!act_reg)
                    begin
                        conc_next = iconc_reg;
                        st_next   = S_INITVOL;
                    end
                    else
                    begin
                        st_next = (area_reg == '0) ? S_HEAD1 : S_LEVEL;
                        if (area_reg == '0) lvl_next = '0;
                    end
                end
            end
            S_INITVOL:
            begin
                if (md_done)
                begin
                    vol_next   = (md_res > full_reg) ? full_reg : md_res;
                    issue_next = 1'b1;
                    st_next    = (area_reg == '0) ? S_HEAD1 : S_LEVEL;
                    if (area_reg == '0) lvl_next = '0;
                end
            end
            S_LEVEL:  if (md_done) begin lvl_next = md_res; st_next = S_HEAD1; issue_next = 1'b1; end
            S_HEAD1:
            begin
                if (md_done)
                begin
                    t_next     = md_res;
                    issue_next = 1'b1;
                    if (lvl_reg > port_reg)
                    begin
                        st_next = S_HEAD2;
                    end
                    else
                    begin
                        press_next = P_ATM;
                        st_next    = S_FLOW1;
                    end
                end
            end
            S_HEAD2:
            begin
                if (md_done)
                begin
                    press_next = psum[VALUE_BITS] ? MAXV : psum[VALUE_BITS-1:0];
                    st_next    = S_FLOW1;
                    issue_next = 1'b1;
                end
            end
            S_FLOW1: if (md_done) begin t_next = md_res; st_next = S_FLOW2; issue_next = 1'b1; end
            S_FLOW2: if (md_done) begin t_next = md_res; st_next = S_FLOW3; issue_next = 1'b1; end
            S_FLOW3:
            begin
                if (md_done)
                begin
                    fout_next  = md_res;
                    issue_next = 1'b1;
                    st_next    = act_reg ? S_INFLOW : S_OUTFLOW;
                    if (!act_reg && area_reg != '0) st_next = S_OUTLEVEL;
                    if (!act_reg && area_reg == '0) lvl_next = '0;
                end
            end
            S_INFLOW:
            begin
                if (md_done)
                begin
                    fin_next = md_res;
                    st_next  = S_SUM;
                end
            end
            S_SUM:
            begin
                tot_next   = tot_ovf ? MAXV : tot_sum;
                issue_next = 1'b1;
                st_next    = S_MIX;
            end
            S_MIX:
            begin
                if (md_done)
                begin
                    if (tot_reg != '0)
                        conc_next = (cin_reg >= conc_reg) ? conc_reg + md_res
                                                          : conc_reg - md_res;
                    if (tot_reg < fout_reg)
                    begin
                        vol_next  = '0;
                        fout_next = '0;
                    end
                    else if (tot_reg - fout_reg > full_reg)
                    begin
                        vol_next = full_reg;
                    end
                    else
                    begin
                        vol_next = tot_reg - fout_reg;
                    end
                    st_next = S_VOLUME;
                end
            end
            S_VOLUME:
            begin
                issue_next = 1'b1;
                if (area_reg == '0)
                begin
                    lvl_next = '0;
                    st_next  = S_OUTFLOW;
                end
                else
                begin
                    st_next = S_OUTLEVEL;
                end
            end
            S_OUTLEVEL: if (md_done) begin lvl_next = md_res; st_next = S_OUTFLOW; issue_next = 1'b1; end
            S_OUTFLOW:  if (md_done) begin fout_next = md_res; st_next = S_DONE; end
            S_DONE:
            begin
                if (!ovalid_reg || !out_stall)
                begin
                    load_out  = 1'b1;
                    busy_next = 1'b0;
                    st_next   = S_IDLE;
                end
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ovalid_next = ovalid_reg;
        if (ovalid_reg && !out_stall) ovalid_next = 1'b0;
        if (load_out) ovalid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= S_IDLE;
            busy_reg      <= 1'b0;
            issue_reg     <= 1'b0;
            ovalid_reg    <= 1'b0;
            vol_reg       <= '0;
            conc_reg      <= '0;
            height_reg    <= VALUE_BITS'(64'd65536);
            diam_reg      <= VALUE_BITS'(64'd65536);
            port_frac_reg <= 17'd32768;
            resist_reg    <= VALUE_BITS'(64'd6553600);
            valve_reg     <= '0;
            fill_reg      <= '0;
            iconc_reg     <= '0;
            tstep_reg     <= VALUE_BITS'(64'd65536);
        end
        else
        begin
            st_reg     <= st_next;
            busy_reg   <= busy_next;
            ovalid_reg <= ovalid_next;
            vol_reg    <= vol_next;
            conc_reg   <= conc_next;
            issue_reg  <= issue_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_HEIGHT:   height_reg    <= cfg_data;
                    REG_DIAMETER: diam_reg      <= cfg_data;
                    REG_PORT:     port_frac_reg <= cfg_data[16:0];
                    REG_RESIST:   resist_reg    <= cfg_data;
                    REG_VALVE:    valve_reg     <= cfg_data[6:0];
                    REG_FILL:     fill_reg      <= cfg_data[6:0];
                    REG_INITCONC: iconc_reg     <= cfg_data;
                    REG_TSTEP:    tstep_reg     <= cfg_data;
                    default:      valve_reg     <= valve_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            act_reg  <= action;
            infl_reg <= inflow_rate;
            dens_reg <= density;
            cin_reg  <= inflow_concentration;
        end
        area_reg  <= area_next;
        full_reg  <= full_next;
        port_reg  <= port_next;
        lvl_reg   <= lvl_next;
        t_reg     <= t_next;
        press_reg <= press_next;
        fout_reg  <= fout_next;
        fin_reg   <= fin_next;
        tot_reg   <= tot_next;
        if (load_out)
        begin
            o_lvl_reg   <= lvl_reg;
            o_conc_reg  <= conc_reg;
            o_flow_reg  <= fout_reg;
            o_press_reg <= press_reg;
        end
    end

    assign out_valid            = ovalid_reg;
    assign liquid_level         = o_lvl_reg;
    assign liquid_concentration = o_conc_reg;
    assign outflow_rate         = o_flow_reg;
    assign outlet_pressure      = o_press_reg;

    property p_idle_free;
        @(posedge clk) disable iff (!rst_n) st_reg == S_IDLE |-> !busy_reg;
    endproperty
    a_idle_free: assert property (p_idle_free) else $error("busy while idle");

    property p_vol_full;
        @(posedge clk) disable iff (!rst_n)
            st_reg == S_VOLUME |-> vol_reg <= full_reg;
    endproperty
    a_vol_full: assert property (p_vol_full) else $error("volume above full");

    property p_done_out;
        @(posedge clk) disable iff (!rst_n) load_out |=> out_valid;
    endproperty
    a_done_out: assert property (p_done_out) else $error("result lost");

endmodule

[test/testbench.sv]
// Self-checking testbench for the tank level, outflow and concentration mixing step.
`timescale 1ns / 1ps

module testbench;
    import tlms_pkg::*;

    typedef logic [VALUE_BITS-1:0] val_t;

    typedef struct {
        val_t level;
        val_t conc;
        val_t outflow;
        val_t pressure;
    } tank_result_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic action;
    val_t inflow_rate;
    val_t density;
    val_t inflow_concentration;
    logic out_valid;
    logic out_stall;
    val_t liquid_level;
    val_t liquid_concentration;
    val_t outflow_rate;
    val_t outlet_pressure;
    logic cfg_valid;
    logic cfg_ready;
    logic [2:0] cfg_index;
    val_t cfg_data;

    // Shadow copy of the configuration and the tank state.
    val_t        m_height, m_diameter, m_resist, m_initconc, m_tstep;
    logic [16:0] m_port;
    logic [6:0]  m_valve, m_fill;
    val_t        m_volume, m_conc;

    tank_result_t pending_results[$];
    int fail_count;
    int result_count;
    int item_count;
    int hold_cycles;
    bit quiet;

    tank_level_mixing_step uut (.*);

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    initial
    begin
        #400ms;
        $display("Timeout with %0d results outstanding", pending_results.size());
        $display("tank_level_mixing_step test failed");
        $finish;
    end

    function automatic val_t mul_div(logic [63:0] a, logic [63:0] b, logic [63:0] c);
        logic [127:0] p;
        logic [127:0] q;
        if (c == 0)
            return MAXV;
        p = {64'd0, a} * {64'd0, b};
        q = p / {64'd0, c};
        if (q > {80'd0, MAXV})
            return MAXV;
        return q[VALUE_BITS-1:0];
    endfunction

    function automatic val_t sat_add(val_t a, val_t b);
        logic [VALUE_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[VALUE_BITS] ? MAXV : s[VALUE_BITS-1:0];
    endfunction

    function automatic tank_result_t advance_tank(logic act, val_t inflow, val_t dens,
                                                  val_t conc_in);
        tank_result_t r;
        val_t area, full, port, level, press, flow, fin, total, c, vol;
        area = mul_div(mul_div(m_diameter, m_diameter, ONE_Q), K_AREA, ONE_Q);
        full = mul_div(area, m_height, ONE_Q);
        port = mul_div(m_port, m_height, ONE_Q);
        if (act == 1'b0)
        begin
            m_conc = m_initconc;
            m_volume = mul_div(full, m_fill, 100);
            if (m_volume > full)
                m_volume = full;
        end
        level = (area == 0) ? '0 : mul_div(m_volume, ONE_Q, area);
        press = P_ATM;
        if (level > port)
            press = sat_add(press, mul_div(mul_div(dens, K_G, ONE_Q), level - port, ONE_Q));
        flow = mul_div(mul_div(press - P_ATM, m_valve, 100), m_tstep, ONE_Q);
        flow = mul_div(flow, ONE_Q, m_resist);
        if (act == 1'b1)
        begin
            c = m_conc;
            fin = mul_div(inflow, m_tstep, 64'd3600 << FRAC_BITS);
            total = sat_add(m_volume, fin);
            if (total != 0)
            begin
                if (conc_in >= c)
                    c = c + mul_div(conc_in - c, fin, total);
                else
                    c = c - mul_div(c - conc_in, fin, total);
            end
            m_conc = c;
            vol = total;
            if (vol < flow)
            begin
                vol = '0;
                flow = '0;
            end
            else
            begin
                vol = vol - flow;
                if (vol > full)
                    vol = full;
            end
            m_volume = vol;
        end
        r.level = (area == 0) ? '0 : mul_div(m_volume, ONE_Q, area);
        r.conc = m_conc;
        r.outflow = mul_div(flow, 3600, 1);
        r.pressure = press;
        return r;
    endfunction

    task automatic report_mismatch(string what, val_t got, val_t want);
        fail_count++;
        if (fail_count <= 30)
            $display("Mismatch at result %0d: %s got %h, expected %h",
                     result_count, what, got, want);
    endtask

    // Each result transfer is checked against the oldest prediction.
    always @(posedge clk)
    begin
        tank_result_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result", liquid_level, '0);
            end
            else
            begin
                w = pending_results.pop_front();
                if (liquid_level !== w.level)
                    report_mismatch("liquid_level", liquid_level, w.level);
                if (liquid_concentration !== w.conc)
                    report_mismatch("liquid_concentration", liquid_concentration, w.conc);
                if (outflow_rate !== w.outflow)
                    report_mismatch("outflow_rate", outflow_rate, w.outflow);
                if (outlet_pressure !== w.pressure)
                    report_mismatch("outlet_pressure", outlet_pressure, w.pressure);
            end
            result_count++;
        end
    end

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_stall <= 1'b1;
                hold_cycles--;
            end
            else if (quiet)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < 8);
        end
    end

    task automatic send_item(logic act, val_t inflow, val_t dens, val_t conc_in);
        int gap;
        gap = quiet ? 0 : (($urandom_range(99) < 8) ? $urandom_range(1, 30) : 0);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        action <= act;
        inflow_rate <= inflow;
        density <= dens;
        inflow_concentration <= conc_in;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.insert(pending_results.size(),
                               advance_tank(act, inflow, dens, conc_in));
        item_count++;
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, val_t value);
        while (pending_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_HEIGHT:   m_height = value;
            REG_DIAMETER: m_diameter = value;
            REG_PORT:     m_port = value[16:0];
            REG_RESIST:   m_resist = value;
            REG_VALVE:    m_valve = value[6:0];
            REG_FILL:     m_fill = value[6:0];
            REG_INITCONC: m_initconc = value;
            REG_TSTEP:    m_tstep = value;
            default:      ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic val_t rand_wide();
        return val_t'({$urandom, $urandom});
    endfunction

    function automatic val_t rand_metres(int lo, int hi);
        return (val_t'($urandom_range(hi, lo)) << FRAC_BITS) | val_t'($urandom_range(65535));
    endfunction

    task automatic set_plant(val_t h, val_t d, val_t port, val_t res, val_t valve,
                             val_t fill, val_t conc, val_t ts);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_DIAMETER, d);
        write_reg(REG_PORT, port);
        write_reg(REG_RESIST, res);
        write_reg(REG_VALVE, valve);
        write_reg(REG_FILL, fill);
        write_reg(REG_INITCONC, conc);
        write_reg(REG_TSTEP, ts);
    endtask

    task automatic test_reset_defaults();
        send_item(1'b1, '0, '0, '0);
        send_item(1'b0, MAXV, MAXV, MAXV);
        send_item(1'b1, 48'd3600 << FRAC_BITS, 48'd1000 << FRAC_BITS, 48'd5 << FRAC_BITS);
        wait_drained();
    endtask

    task automatic test_directed_cases();
        set_plant(48'd4 << FRAC_BITS, ONE_Q, 48'd16384, ONE_Q, 48'd100, 48'd100,
                  48'd2 << FRAC_BITS, ONE_Q);
        send_item(1'b0, '0, 48'd1000 << FRAC_BITS, '0);
        send_item(1'b1, 48'd100 << FRAC_BITS, 48'd1000 << FRAC_BITS, 48'd9 << FRAC_BITS);
        send_item(1'b1, '0, 48'd1000 << FRAC_BITS, '0);
        send_item(1'b1, MAXV, MAXV, MAXV);
        send_item(1'b1, '0, MAXV, '0);
        wait_drained();
        // Fill above full, port above the top, then a drain far larger than the volume.
        write_reg(REG_FILL, 48'd127);
        write_reg(REG_PORT, 48'h1FFFF);
        send_item(1'b0, '0, '0, '0);
        send_item(1'b1, '0, MAXV, '0);
        write_reg(REG_PORT, '0);
        write_reg(REG_FILL, 48'd1);
        write_reg(REG_TSTEP, 48'd1000 << FRAC_BITS);
        send_item(1'b0, '0, 48'd1000 << FRAC_BITS, '0);
        send_item(1'b1, 48'd1, 48'd1000 << FRAC_BITS, MAXV);
        wait_drained();
        // Port exactly at one, zero resistance, then an empty tank with zero inflow.
        write_reg(REG_PORT, 48'd65536);
        write_reg(REG_RESIST, '0);
        write_reg(REG_FILL, 48'd50);
        send_item(1'b0, '0, 48'd1000 << FRAC_BITS, '0);
        write_reg(REG_PORT, '0);
        send_item(1'b1, '0, 48'd1000 << FRAC_BITS, '0);
        write_reg(REG_RESIST, ONE_Q);
        write_reg(REG_FILL, '0);
        send_item(1'b0, '0, '0, '0);
        send_item(1'b1, '0, '0, MAXV);
        wait_drained();
        // Zero tank area and extreme registers.
        write_reg(REG_DIAMETER, '0);
        send_item(1'b1, 48'd3600 << FRAC_BITS, 48'd1000 << FRAC_BITS, MAXV);
        send_item(1'b0, '0, '0, '0);
        wait_drained();
        set_plant(MAXV, MAXV, 48'h1FFFF, MAXV, 48'd127, 48'd127, MAXV, MAXV);
        send_item(1'b0, MAXV, MAXV, MAXV);
        send_item(1'b1, MAXV, MAXV, '0);
        set_plant('0, '0, '0, 48'd1, '0, '0, '0, '0);
        send_item(1'b1, MAXV, MAXV, MAXV);
        send_item(1'b0, MAXV, MAXV, MAXV);
        wait_drained();
    endtask

    task automatic random_plant();
        if ($urandom_range(9) == 0)
        begin
            set_plant(rand_wide(), rand_wide(), val_t'($urandom_range(131071)), rand_wide(),
                      val_t'($urandom_range(127)), val_t'($urandom_range(127)),
                      rand_wide(), rand_wide());
        end
        else
        begin
            set_plant(rand_metres(1, 10), rand_metres(0, 3), val_t'($urandom_range(65536)),
                      rand_metres(0, 100), val_t'($urandom_range(100)),
                      val_t'($urandom_range(100)), rand_metres(0, 50), rand_metres(1, 600));
        end
    endtask

    task automatic random_steps(int count);
        logic act;
        val_t inflow, dens, conc_in;
        for (int i = 0; i < count; i++)
        begin
            act = (i == 0) ? 1'b0 : ($urandom_range(99) >= 4);
            if ($urandom_range(9) == 0)
            begin
                inflow = rand_wide();
                dens = rand_wide();
                conc_in = rand_wide();
            end
            else
            begin
                inflow = rand_metres(0, 20000);
                dens = rand_metres(500, 1500);
                conc_in = rand_metres(0, 50);
            end
            send_item(act, inflow, dens, conc_in);
        end
    endtask

    task automatic test_backpressure();
        wait_drained();
        hold_cycles = 8000;
        random_steps(5);
        wait_drained();
    endtask

    task automatic test_random();
        for (int phase = 0; phase < 12; phase++)
        begin
            random_plant();
            quiet = (phase == 5);
            random_steps(145);
            wait_drained();
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = 1'b0;
        inflow_rate = '0;
        density = '0;
        inflow_concentration = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_HEIGHT;
        cfg_data = '0;
        fail_count = 0;
        result_count = 0;
        item_count = 0;
        hold_cycles = 0;
        quiet = 1'b0;
        m_height = ONE_Q;
        m_diameter = ONE_Q;
        m_port = 17'd32768;
        m_resist = 48'd6553600;
        m_valve = '0;
        m_fill = '0;
        m_initconc = '0;
        m_tstep = ONE_Q;
        m_volume = '0;
        m_conc = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_directed_cases();
        test_backpressure();
        test_random();
        wait_drained();

        $display("Sent %0d items and checked %0d results over 12 random plant settings,",
                 item_count, result_count);
        $display("with directed extremes, a long output hold-off and %0d mismatches.",
                 fail_count);
        if (fail_count == 0)
            $display("tank_level_mixing_step test passed");
        else
            $display("tank_level_mixing_step test failed");
        $finish;
    end

endmodule

[files.f]
rtl/tlms_pkg.sv
rtl/tlms_muldiv.sv
rtl/tank_level_mixing_step.sv
test/testbench.sv
